@@ rtl/sem_pkg.sv @@
// Shared constants and types for the Sobel edge magnitude block.
package sem_pkg;

    localparam int MaxWidth = 2048;
    localparam int ColW = $clog2(MaxWidth);
    localparam int NumLanes = 3;

    localparam logic [11:0] WidthReset = 12'd640;
    localparam logic [15:0] HeightReset = 16'd480;

    typedef enum logic {
        CFG_WIDTH = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    // Window of one channel, [row*3 + col], rows top..bottom, cols left..right
    typedef logic [8:0][7:0] t_win;

    typedef struct packed {
        logic [2:0] rv;
        logic [2:0] cv;
    } t_mask;

endpackage

@@ rtl/sem_grad.sv @@
// One channel lane: Sobel gradients, squared magnitude, pipelined.
module sem_grad
    import sem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_win        i_win,
    input  t_mask       i_mask,
    output logic [16:0] o_sum
);

    logic [8:0][7:0] w;
    logic signed [11:0] gx, gy;
    logic signed [11:0] r_gx, r_gy;
    logic [21:0] r_sum;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w[i] = (i_mask.rv[i / 3] && i_mask.cv[i % 3]) ? i_win[i] : 8'd0;
        end
        gx = $signed({4'd0, w[2]}) - $signed({4'd0, w[0]})
           + $signed({3'd0, w[5], 1'b0}) - $signed({3'd0, w[3], 1'b0})
           + $signed({4'd0, w[8]}) - $signed({4'd0, w[6]});
        gy = $signed({4'd0, w[6]}) - $signed({4'd0, w[0]})
           + $signed({3'd0, w[7], 1'b0}) - $signed({3'd0, w[1], 1'b0})
           + $signed({4'd0, w[8]}) - $signed({4'd0, w[2]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx <= gx;
            r_gy <= gy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= 22'(r_gx * r_gx) + 22'(r_gy * r_gy);
        end
    end

    // saturate above the rounding threshold of 255
    assign o_sum = (r_sum > 22'd65280) ? 17'd65535 : r_sum[16:0];

endmodule

@@ rtl/sem_sqrt.sv @@
// Merging stage: rounded integer square root of each lane, result staging.
module sem_sqrt
    import sem_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic                      i_last,
    input  logic [NumLanes-1:0][16:0] i_sum,
    output logic                      o_vld,
    output logic                      o_last,
    output logic [NumLanes-1:0][7:0]  o_mag
);

    // digit pipeline: stage k decides bit 7-k
    logic [8:0]                     r_v;
    logic [8:0]                     r_l;
    logic [8:0][NumLanes-1:0][16:0] r_s;
    logic [8:0][NumLanes-1:0][7:0]  r_m;
    logic [NumLanes-1:0][8:0]       fin;
    logic [NumLanes-1:0][7:0]       n_m [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int l = 0; l < NumLanes; l++) begin
                logic [7:0] t;
                t = r_m[k][l] | (8'd128 >> k);
                n_m[k][l] = (17'(t * t) <= r_s[k][l]) ? t : r_m[k][l];
            end
        end
        for (int l = 0; l < NumLanes; l++) begin
            fin[l] = (r_s[8][l] > 17'(r_m[8][l] * r_m[8][l]) + 17'(r_m[8][l]))
                   ? 9'(r_m[8][l]) + 9'd1 : 9'(r_m[8][l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l[0] <= i_last;
            r_s[0] <= i_sum;
            r_m[0] <= '0;
            for (int k = 0; k < 8; k++) begin
                r_l[k+1] <= r_l[k];
                r_s[k+1] <= r_s[k];
                r_m[k+1] <= n_m[k];
            end
        end
    end

    always_comb begin
        o_vld  = r_v[8];
        o_last = r_l[8];
        for (int l = 0; l < NumLanes; l++) begin
            o_mag[l] = fin[l][8] ? 8'd255 : fin[l][7:0];
        end
    end

endmodule

@@ rtl/sobel_edge_magnitude_rgb.sv @@
// Top level: line buffers, window, counters, three lanes and output register.
// Pipeline: a result leaves, after the item that releases it is taken, through
// memory read, window, two gradient stages, nine root stages and output.
// Throughput: one item per cycle; the whole pipeline stalls while the
// output register is full and not taken, and input waits during a config write.
// Reset: synchronous, active low; counters and valid bits clear, the size registers
// return to 640 x 480; line buffer contents stay undefined and never reach a result.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue_in, green_in, red_in
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // blue_edge, green_edge, red_edge
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [11:0] r_width;
    logic [15:0] r_height;
    logic [12:0] w_eff;
    logic [15:0] h_eff;

    logic [ColW-1:0] r_icol, r_ocol;
    logic [16:0]     r_irow;
    logic [15:0]     r_orow;

    logic [23:0] r_prev [MaxWidth];
    logic [23:0] r_prev2 [MaxWidth];
    logic [23:0] r_top, r_mid, r_px;
    logic [23:0] r_mid0;
    logic        r_dbl;
    logic        r_shift;
    logic [8:0][23:0] r_win;
    logic        r_ovld, r_olast;
    t_mask       r_omask;

    logic        en, take, cfg_wr;
    logic        complete, adv, adv2, emit1, emit2, emit;
    logic        gen1, gen2;
    logic [ColW-1:0] col2;
    logic [16:0] row2;
    logic [ColW-1:0] n_icol;
    logic [16:0] n_irow;
    logic [23:0] px;
    t_mask       mask;
    logic        last;
    logic [ColW-1:0] c_col;
    logic [16:0] c_row;

    logic                      sq_vld, sq_last;
    logic [NumLanes-1:0][16:0] sum;
    logic [NumLanes-1:0][7:0]  mag;
    logic                      r_mvalid, r_mlast;
    logic [23:0]               r_mdata;

    assign w_eff = (r_width == 12'd0) ? 13'd1 :
                   (13'(r_width) > 13'(MaxWidth)) ? 13'(MaxWidth) : 13'(r_width);
    assign h_eff = (r_height == 16'd0) ? 16'd1 : r_height;

    assign en    = !r_mvalid || m_axis_tready;
    assign cfg_wr = i_cfg_valid;
    assign s_axis_tready = en && !cfg_wr;
    assign o_cfg_ready = 1'b1;
    assign take  = s_axis_tvalid && s_axis_tready;

    // first virtual step
    assign complete = r_irow >= 17'(h_eff);
    assign gen1 = (r_irow >= 17'd2) || (r_irow == 17'd1 && r_icol != '0);
    assign adv  = take && (complete ? 1'b1 : !s_axis_tuser);
    assign emit1 = adv && gen1;
    assign px   = complete ? 24'd0 : s_axis_tdata;
    assign c_col = (13'(r_icol) + 13'd1 >= w_eff) ? '0 : r_icol + 1'b1;
    assign c_row = (13'(r_icol) + 13'd1 >= w_eff) ? r_irow + 17'd1 : r_irow;
    // second step only on a one-row frame drain with no result on the first
    assign col2 = c_col;
    assign row2 = c_row;
    assign gen2 = (row2 >= 17'd2) || (row2 == 17'd1 && col2 != '0);
    assign adv2 = take && complete && !gen1;
    assign emit2 = adv2 && gen2;
    assign emit = emit1 || emit2;
    assign n_icol = adv2 ? ((13'(col2) + 13'd1 >= w_eff) ? '0 : col2 + 1'b1) : c_col;
    assign n_irow = adv2 ? ((13'(col2) + 13'd1 >= w_eff) ? row2 + 17'd1 : row2) : c_row;

    always_comb begin
        mask.rv = {17'(r_orow) + 17'd1 < 17'(h_eff), 1'b1, r_orow != '0};
        mask.cv = {13'(r_ocol) + 13'd1 < w_eff, 1'b1, r_ocol != '0};
        last = (17'(r_orow) + 17'd1 >= 17'(h_eff)) && (13'(r_ocol) + 13'd1 >= w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_shift <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (en) begin
                r_shift <= adv || adv2;
                r_ovld  <= emit;
            end
            if (cfg_wr) begin
                if (t_cfg_index'(i_cfg_index) == CFG_WIDTH) begin
                    r_width <= i_cfg_data[11:0];
                end else begin
                    r_height <= i_cfg_data;
                end
                r_icol <= '0;
                r_irow <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else if (adv || adv2) begin
                r_icol <= n_icol;
                r_irow <= n_irow;
                if (emit) begin
                    if (last) begin
                        r_icol <= '0;
                        r_irow <= '0;
                        r_ocol <= '0;
                        r_orow <= '0;
                    end else if (13'(r_ocol) + 13'd1 >= w_eff) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 16'd1;
                    end else begin
                        r_ocol <= r_ocol + 1'b1;
                    end
                end
            end
        end
    end

    // line buffers: the second virtual step always writes zeros at col2
    always_ff @(posedge i_clk) begin
        if (adv || adv2) begin
            r_prev[adv2 ? col2 : r_icol]  <= adv2 ? 24'd0 : px;
            r_prev2[adv2 ? col2 : r_icol] <= r_prev[adv2 ? col2 : r_icol];
            r_top <= r_prev2[adv2 ? col2 : r_icol];
            r_mid <= r_prev[adv2 ? col2 : r_icol];
            r_px  <= adv2 ? 24'd0 : px;
            // middle place of the skipped first step feeds the window center
            r_mid0 <= r_prev[r_icol];
            r_dbl  <= adv2;
        end
        if (en) begin
            r_omask <= mask;
            r_olast <= last;
        end
    end

    // window shift takes the registered memory read when not stalled; masked places hide stale data
    always_ff @(posedge i_clk) begin
        if (en && r_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[3] <= r_win[4];
            r_win[4] <= r_dbl ? r_mid0 : r_win[5];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[2] <= r_top;
            r_win[5] <= r_mid;
            r_win[8] <= r_px;
        end
    end

    // mask and last pass through r_gmask and r_glast into the lanes along with the window
    logic  r_gvld, r_glast;
    t_mask r_gmask;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld <= 1'b0;
        end else if (en) begin
            r_gvld <= r_ovld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gmask <= r_omask;
            r_glast <= r_olast;
        end
    end

    logic [2:0] r_lv;
    logic [2:0] r_ll;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= '0;
        end else if (en) begin
            r_lv <= {r_lv[1:0], r_gvld};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ll <= {r_ll[1:0], r_glast};
        end
    end

    t_win wl [NumLanes];
    genvar g;
    generate
        for (g = 0; g < NumLanes; g++) begin : g_lane
            always_comb begin
                for (int i = 0; i < 9; i++) begin
                    wl[g][i] = r_win[i][8*g +: 8];
                end
            end
            sem_grad u_grad (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_win  (wl[g]),
                .i_mask (r_gmask),
                .o_sum  (sum[g])
            );
        end
    endgenerate

    // window and mask are both current alongside r_gvld; r_lv and r_ll match the gradient registers
    sem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_lv[1]),
        .i_last  (r_ll[1]),
        .i_sum   (sum),
        .o_vld   (sq_vld),
        .o_last  (sq_last),
        .o_mag   (mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (en) begin
            r_mvalid <= sq_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdata <= {mag[2], mag[1], mag[0]};
            r_mlast <= sq_last;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit1 && emit2))
        else $error("two results in one item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_irow <= 17'(h_eff) + 17'd2))
        else $error("input row ran away");

endmodule
